>>> design/uxv_pkg.sv
// shared types and constants for the utf-8 xml text validator
package uxv_pkg;

   localparam int CP_W = 21;

   localparam logic [CP_W-1:0] CP_MIN_2       = 21'h000080;
   localparam logic [CP_W-1:0] CP_MIN_3       = 21'h000800;
   localparam logic [CP_W-1:0] CP_MIN_4       = 21'h010000;
   localparam logic [CP_W-1:0] CP_SURR_LO     = 21'h00D800;
   localparam logic [CP_W-1:0] CP_SURR_HI     = 21'h00DFFF;
   localparam logic [CP_W-1:0] CP_MAX         = 21'h10FFFF;
   localparam logic [CP_W-1:0] CP_TAB         = 21'h000009;
   localparam logic [CP_W-1:0] CP_LF          = 21'h00000A;
   localparam logic [CP_W-1:0] CP_CR          = 21'h00000D;
   localparam logic [CP_W-1:0] CP_SPACE       = 21'h000020;
   localparam logic [CP_W-1:0] CP_BMP_LO_END  = 21'h00D7FF;
   localparam logic [CP_W-1:0] CP_BMP_HI_BASE = 21'h00E000;
   localparam logic [CP_W-1:0] CP_BMP_HI_END  = 21'h00FFFD;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_INVALID   = 3'd1,
      ST_TRUNCATED = 3'd2,
      ST_NONCANON  = 3'd3,
      ST_FORBIDDEN = 3'd4
   } status_type;

   typedef struct packed {
      logic            char_done;
      logic [CP_W-1:0] code_point;
      logic            string_end;
      status_type      status;
   } step_result_type;

endpackage

>>> design/uxv_cp_check.sv
// canonical form and xml 1.0 character set check of a finished code point
module uxv_cp_check
   import uxv_pkg::*;
(
   input  logic [CP_W-1:0] value,
   input  logic [2:0]      seq_length,
   output status_type      status
);

   logic [CP_W-1:0] min_value;
   logic            noncanon;
   logic            allowed;

   always_comb begin
      case (seq_length)
         3'd2:    min_value = CP_MIN_2;
         3'd3:    min_value = CP_MIN_3;
         3'd4:    min_value = CP_MIN_4;
         default: min_value = '0;
      endcase
   end

   assign noncanon = (value < min_value) ||
                     (value >= CP_SURR_LO && value <= CP_SURR_HI) ||
                     (value > CP_MAX);

   assign allowed = (value == CP_TAB) || (value == CP_LF) || (value == CP_CR) ||
                    (value >= CP_SPACE && value <= CP_BMP_LO_END) ||
                    (value >= CP_BMP_HI_BASE && value <= CP_BMP_HI_END) ||
                    (value >= CP_MIN_4 && value <= CP_MAX);

   always_comb begin
      if (noncanon) begin
         status = ST_NONCANON;
      end else if (!allowed) begin
         status = ST_FORBIDDEN;
      end else begin
         status = ST_OK;
      end
   end

endmodule

>>> design/uxv_decode.sv
// decoder state and one-byte step of the utf-8 sequence machine
module uxv_decode
   import uxv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic [7:0]      data_byte,
   input  logic            last_byte,
   output step_result_type result
);

   logic [1:0]      bytes_left_ff, bytes_left_in, bytes_left_mid;
   logic [2:0]      seq_length_ff, seq_length_in, seq_length_mid;
   logic [CP_W-1:0] partial_value_ff, partial_value_in, partial_value_mid;
   logic            bad_cont_ff, bad_cont_in, bad_cont_mid;
   status_type      error_ff, error_in, error_mid;
   status_type      check_status;

   // lead or continuation byte
   always_comb begin
      bytes_left_mid    = bytes_left_ff;
      seq_length_mid    = seq_length_ff;
      partial_value_mid = partial_value_ff;
      bad_cont_mid      = bad_cont_ff;
      error_mid         = error_ff;
      if (error_ff == ST_OK) begin
         if (bytes_left_ff == 2'd0) begin
            bad_cont_mid = 1'b0;
            if (data_byte[7] == 1'b0) begin
               partial_value_mid = {13'd0, data_byte};
               seq_length_mid    = 3'd1;
               bytes_left_mid    = 2'd0;
            end else if (data_byte[7:5] == 3'b110) begin
               partial_value_mid = {16'd0, data_byte[4:0]};
               seq_length_mid    = 3'd2;
               bytes_left_mid    = 2'd1;
            end else if (data_byte[7:4] == 4'b1110) begin
               partial_value_mid = {17'd0, data_byte[3:0]};
               seq_length_mid    = 3'd3;
               bytes_left_mid    = 2'd2;
            end else if (data_byte[7:3] == 5'b11110) begin
               partial_value_mid = {18'd0, data_byte[2:0]};
               seq_length_mid    = 3'd4;
               bytes_left_mid    = 2'd3;
            end else begin
               error_mid = ST_INVALID;
            end
         end else begin
            if (data_byte[7:6] != 2'b10) begin
               bad_cont_mid = 1'b1;
            end
            partial_value_mid = {partial_value_ff[CP_W-7:0], data_byte[5:0]};
            bytes_left_mid    = bytes_left_ff - 2'd1;
         end
      end
   end

   uxv_cp_check u_cp_check (
      .value      (partial_value_mid),
      .seq_length (seq_length_mid),
      .status     (check_status)
   );

   // sequence end and string end
   always_comb begin
      bytes_left_in     = bytes_left_mid;
      seq_length_in     = seq_length_mid;
      partial_value_in  = partial_value_mid;
      bad_cont_in       = bad_cont_mid;
      error_in          = error_mid;
      result.char_done  = 1'b0;
      result.code_point = '0;
      result.string_end = last_byte;
      if (error_ff == ST_OK && error_mid == ST_OK && bytes_left_mid == 2'd0) begin
         if (bad_cont_mid) begin
            error_in = ST_INVALID;
         end else if (check_status != ST_OK) begin
            error_in = check_status;
         end else begin
            result.char_done  = 1'b1;
            result.code_point = partial_value_mid;
         end
         partial_value_in = '0;
         seq_length_in    = 3'd0;
         bad_cont_in      = 1'b0;
      end
      if (last_byte && error_in == ST_OK && bytes_left_mid != 2'd0) begin
         error_in = ST_TRUNCATED;
      end
      result.status = error_in;
      if (last_byte) begin
         bytes_left_in    = 2'd0;
         seq_length_in    = 3'd0;
         partial_value_in = '0;
         bad_cont_in      = 1'b0;
         error_in         = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff    <= 2'd0;
         seq_length_ff    <= 3'd0;
         partial_value_ff <= '0;
         bad_cont_ff      <= 1'b0;
         error_ff         <= ST_OK;
      end else if (advance) begin
         bytes_left_ff    <= bytes_left_in;
         seq_length_ff    <= seq_length_in;
         partial_value_ff <= partial_value_in;
         bad_cont_ff      <= bad_cont_in;
         error_ff         <= error_in;
      end
   end

   // no open sequence without a length while error free
   a_len_matches_left: assert property (@(posedge clock) disable iff (reset)
      (error_ff == ST_OK) |-> ((bytes_left_ff == 2'd0) == (seq_length_ff == 3'd0)))
      else $error("sequence length and bytes left disagree");

   // bad continuation flag is cleared once a sequence closes
   a_bad_cleared: assert property (@(posedge clock) disable iff (reset)
      (error_ff == ST_OK && bytes_left_ff == 2'd0) |-> !bad_cont_ff)
      else $error("bad continuation flag left set");

   // string end always leaves a clean state
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && last_byte) |=> (error_ff == ST_OK && bytes_left_ff == 2'd0))
      else $error("state not cleared after last item");

endmodule

>>> design/utf8_xml_text_validator.sv
// top level: input register, decode step and result register
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_ready | req_data_byte, req_last_byte
//   rsp     | out       | rsp_valid/rsp_ready | rsp_char_done, rsp_code_point,
//           |           |                     | rsp_string_end, rsp_status
//
// one item per cycle sustained while rsp_ready is high; each result is registered
// the input register and the result register each hold one item, so a new item is
// taken while a finished result waits; the decode step runs as the item moves across
// reset is synchronous, clears the decoder state and empties both registers
// when rsp_ready is low both registers fill and then req_ready drops
module utf8_xml_text_validator
   import uxv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [7:0]      req_data_byte,
   input  logic            req_last_byte,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic            rsp_char_done,
   output logic [CP_W-1:0] rsp_code_point,
   output logic            rsp_string_end,
   output logic [2:0]      rsp_status
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   step_result_type rsp_ff;
   step_result_type step_result;
   logic            advance;
   logic            take;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   uxv_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_done  = rsp_ff.char_done;
   assign rsp_code_point = rsp_ff.code_point;
   assign rsp_string_end = rsp_ff.string_end;
   assign rsp_status     = rsp_ff.status;

   // a decoded character never carries an error
   a_done_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_char_done) |-> (rsp_status == ST_OK))
      else $error("character reported with error status");

   // code point is zero unless a character completes
   a_cp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_char_done) |-> (rsp_code_point == '0))
      else $error("stray code point");

   // input stalls only when both registers are full and the result is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without backpressure");

endmodule
